/* sv/ctpst_pkg.sv */
// Package for the cookie-tagged packet slot table.
// Holds table geometry, operation kinds and result status codes.
// No dependencies; imported by ctpst_ctrl, ctpst_dp and the top level.
package ctpst_pkg;

  localparam int SLOT_BITS   = 8;
  localparam int COOKIE_BITS = 24;
  localparam int NSLOTS      = 1 << SLOT_BITS;

  localparam logic [30:0] HOLD_TIME_RESET = 31'd1000;

  // Operation kinds
  localparam logic [1:0] KIND_STORE       = 2'd0;
  localparam logic [1:0] KIND_RETRIEVE    = 2'd1;
  localparam logic [1:0] KIND_DISCARD     = 2'd2;
  localparam logic [1:0] KIND_DISCARD_ALL = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_BUSY        = 3'd1;
  localparam logic [2:0] ST_RETRIEVED   = 3'd2;
  localparam logic [2:0] ST_RETR_MISS   = 3'd3;
  localparam logic [2:0] ST_DISCARDED   = 3'd4;
  localparam logic [2:0] ST_DISC_MISS   = 3'd5;
  localparam logic [2:0] ST_ALL_CLEARED = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic issue;  // capture the request and read its slot row
    logic exec;   // check the slot, write back, load the result register
  } ctpst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;  // result register full and not taken this cycle
  } ctpst_sts_t;

endpackage

/* sv/ctpst_if.sv */
// Request and response channel interfaces of the packet slot table.
// Depends on nothing; valid/ready handshake with the payload fields.
interface ctpst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] handle;
  logic [31:0] buffer_id;
  logic [31:0] now;

  modport source (output valid, kind, handle, buffer_id, now, input ready);
  modport sink   (input valid, kind, handle, buffer_id, now, output ready);
endinterface

interface ctpst_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] result_id;
  logic [31:0] result_handle;
  logic [31:0] released_handle;
  logic        released_valid;

  modport source (output valid, status, result_id, result_handle, released_handle,
                  released_valid, input ready);
  modport sink   (input valid, status, result_id, result_handle, released_handle,
                  released_valid, output ready);
endinterface

/* sv/ctpst_ctrl.sv */
// Controller of the packet slot table: two-state sequencer.
// Depends on ctpst_pkg for the command and status structs.
module ctpst_ctrl
  import ctpst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  ctpst_sts_t sts_i,
  output ctpst_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.issue = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the new result
        if (!sts_i.out_stall) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/ctpst_dp.sv */
// Datapath of the packet slot table: slot row memory, valid marks,
// ring index, hold time register and result register. Uses ctpst_pkg.
module ctpst_dp
  import ctpst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  ctpst_req_if.sink          req_i,
  ctpst_rsp_if.source        rsp_o,
  input  ctpst_cmd_t         cmd_i,
  output ctpst_sts_t         sts_o
);

  typedef struct packed {
    logic [31:0]            handle;
    logic [31:0]            expiry;
    logic [COOKIE_BITS-1:0] cookie;
  } row_t;

  row_t mem [NSLOTS];
  row_t rd_q;
  row_t wr_row;
  logic mem_we;

  logic [NSLOTS-1:0]    valid_q;
  logic [NSLOTS-1:0]    init_q;   // cookie written since reset
  logic [SLOT_BITS-1:0] ring_q;
  logic [30:0]          hold_q;

  logic [1:0]           kind_q;
  logic [SLOT_BITS-1:0] slot_q;
  logic [31:0]          handle_q;
  logic [31:0]          bid_q;
  logic [31:0]          now_q;

  logic [SLOT_BITS-1:0] rd_addr;
  logic [SLOT_BITS-1:0] ring_next;

  logic                   cur_valid;
  logic [COOKIE_BITS-1:0] cur_cookie;
  logic [COOKIE_BITS-1:0] cookie_inc;
  logic [COOKIE_BITS-1:0] new_cookie;
  logic [31:0]            age;
  logic                   hit;

  logic        set_valid, clr_valid, clr_all;
  logic [2:0]  res_status;
  logic [31:0] res_id, res_handle, res_rel;
  logic        res_relv;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_id_q, out_handle_q, out_rel_q;
  logic        out_relv_q;

  assign ring_next = ring_q + 1'b1;
  assign rd_addr   = (req_i.kind == KIND_STORE) ? ring_next
                                                : req_i.buffer_id[SLOT_BITS-1:0];

  assign cur_valid  = valid_q[slot_q];
  assign cur_cookie = init_q[slot_q] ? rd_q.cookie : '0;
  assign cookie_inc = cur_cookie + 1'b1;
  assign new_cookie = (cookie_inc == '1) ? '0 : cookie_inc;
  assign age        = now_q - rd_q.expiry;
  assign hit        = cur_valid && ((bid_q >> SLOT_BITS) == 32'(cur_cookie));

  assign wr_row.handle = handle_q;
  assign wr_row.expiry = now_q + {1'b0, hold_q};
  assign wr_row.cookie = new_cookie;

  always_comb begin
    res_status = ST_ALL_CLEARED;
    res_id     = '0;
    res_handle = '0;
    res_rel    = '0;
    res_relv   = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    clr_all    = 1'b0;
    unique case (kind_q)
      KIND_STORE: begin
        if (cur_valid && age[31]) begin
          res_status = ST_BUSY;
        end else begin
          res_status = ST_STORED;
          res_id     = 32'(slot_q) | (32'(new_cookie) << SLOT_BITS);
          res_rel    = cur_valid ? rd_q.handle : '0;
          res_relv   = cur_valid;
          set_valid  = 1'b1;
        end
      end
      KIND_RETRIEVE: begin
        if (hit) begin
          res_status = ST_RETRIEVED;
          res_handle = rd_q.handle;
          clr_valid  = 1'b1;
        end else begin
          res_status = ST_RETR_MISS;
        end
      end
      KIND_DISCARD: begin
        if (hit) begin
          res_status = ST_DISCARDED;
          res_rel    = rd_q.handle;
          res_relv   = 1'b1;
          clr_valid  = 1'b1;
        end else begin
          res_status = ST_DISC_MISS;
        end
      end
      KIND_DISCARD_ALL: begin
        res_status = ST_ALL_CLEARED;
        clr_all    = 1'b1;
      end
      default: res_status = ST_ALL_CLEARED;
    endcase
  end

  assign mem_we = cmd_i.exec && set_valid;

  // slot row memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_q] <= wr_row;
    end
    if (cmd_i.issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      kind_q   <= req_i.kind;
      slot_q   <= rd_addr;
      handle_q <= req_i.handle;
      bid_q    <= req_i.buffer_id;
      now_q    <= req_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      init_q  <= '0;
      ring_q  <= '0;
      hold_q  <= HOLD_TIME_RESET;
    end else begin
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      // advance the ring on every store, refused or not
      if (cmd_i.issue && (req_i.kind == KIND_STORE)) begin
        ring_q <= ring_next;
      end
      if (cmd_i.exec) begin
        if (clr_all) begin
          valid_q <= '0;
        end else if (set_valid) begin
          valid_q[slot_q] <= 1'b1;
          init_q[slot_q]  <= 1'b1;
        end else if (clr_valid) begin
          valid_q[slot_q] <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
      out_handle_q <= res_handle;
      out_rel_q    <= res_rel;
      out_relv_q   <= res_relv;
    end
  end

  assign sts_o.out_stall = out_valid_q && !rsp_o.ready;

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.result_id       = out_id_q;
  assign rsp_o.result_handle   = out_handle_q;
  assign rsp_o.released_handle = out_rel_q;
  assign rsp_o.released_valid  = out_relv_q;

endmodule

/* sv/cookie_tagged_packet_slot_table.sv */
// Top level of the cookie-tagged packet slot table.
// Depends on ctpst_pkg, ctpst_if, ctpst_ctrl and ctpst_dp.
//
//   Channel   Dir  Handshake        Payload
//   req_i     in   valid/ready      kind, handle, buffer_id, now
//   rsp_o     out  valid/ready      status, result_id, result_handle,
//                                   released_handle, released_valid
//   cfg       in   cfg_we_i only    cfg_wdata_i (hold_time)
//
// Each transaction is accepted in S_IDLE, which reads the slot row
// from the slot memory; in S_EXEC, once the result register can take
// the result, it checks the slot, writes the row back and loads the result.
// The next request is taken while a result still waits in that register;
// only a second result behind a stalled one holds the controller.
// Reset clears the valid marks, cookie-written flags and ring index at
// once, so no clearing pass follows it; hold_time returns to 1000.
module cookie_tagged_packet_slot_table
  import ctpst_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,
  ctpst_req_if.sink    req_i,
  ctpst_rsp_if.source  rsp_o
);

  ctpst_cmd_t cmd;
  ctpst_sts_t sts;
  logic       req_ready;

  // sequence each transaction: capture, then execute
  ctpst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // slot storage, result logic and result register
  ctpst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
